/* rtl/core/transfer_table_block_allocator_top_defines.svh */
// Assertion macros used by the block's checker.
`ifndef TRANSFER_TABLE_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define TRANSFER_TABLE_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define TTBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define TTBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ttba_pkg.sv */
// Package with shared constants, codes and types of the transfer table allocator.
`timescale 1ns / 1ps
package ttba_pkg;

  localparam int DESCRIPTORS_DEF = 4;
  localparam int BLOCKS_DEF      = 64;
  localparam int BLOCK_BYTES_DEF = 64;

  localparam int ADDR_W   = 24;
  localparam int SIZE_W   = 24;
  localparam int SRC_W    = 16;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int PADDR_W  = 3;

  localparam logic [1:0] OP_OPEN    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_MARK    = 2'd2;

  localparam logic [2:0] ST_SUCCESS     = 3'd0;
  localparam logic [2:0] ST_EXISTS      = 3'd1;
  localparam logic [2:0] ST_COMPLETE    = 3'd2;
  localparam logic [2:0] ST_NO_RESOURCE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd5;

  localparam logic REG_BASE_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_FREE
  } res_sel_t;

  typedef struct packed {
    logic       capture;
    logic       set_res;
    logic [2:0] res_status;
    res_sel_t   res_sel;
    logic       release_hit;
    logic       mark_hit;
    logic       scan_init;
    logic       scan_step;
    logic       alloc;
    logic       load_out;
  } ttba_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       size_zero;
    logic       hit;
    logic       hit_done;
    logic       free_found;
    logic       scan_hit;
    logic       scan_last;
  } ttba_stat_t;

endpackage

/* rtl/core/ttba_ctrl.sv */
// Controller state machine that sequences lookup, block scan and result delivery.
`timescale 1ns / 1ps
module ttba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  ttba_pkg::ttba_stat_t  stat,
  output ttba_pkg::ttba_cmd_t   cmd
);

  ttba_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.res_sel   = ttba_pkg::RES_NONE;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ttba_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ttba_pkg::S_DECIDE;
        end
      end
      ttba_pkg::S_DECIDE: begin
        state_nxt   = ttba_pkg::S_FINISH;
        cmd.set_res = 1'b1;
        case (stat.op)
          ttba_pkg::OP_OPEN: begin
            if (stat.size_zero) begin
              cmd.res_status = ttba_pkg::ST_BAD_SIZE;
            end else if (stat.hit) begin
              cmd.res_status = stat.hit_done ? ttba_pkg::ST_COMPLETE : ttba_pkg::ST_EXISTS;
              cmd.res_sel    = ttba_pkg::RES_HIT;
            end else if (!stat.free_found) begin
              cmd.res_status = ttba_pkg::ST_NO_RESOURCE;
            end else begin
              cmd.set_res   = 1'b0;
              cmd.scan_init = 1'b1;
              state_nxt     = ttba_pkg::S_SCAN;
            end
          end
          ttba_pkg::OP_RELEASE, ttba_pkg::OP_MARK: begin
            if (stat.hit) begin
              cmd.res_status  = ttba_pkg::ST_SUCCESS;
              cmd.res_sel     = ttba_pkg::RES_HIT;
              cmd.release_hit = (stat.op == ttba_pkg::OP_RELEASE);
              cmd.mark_hit    = (stat.op == ttba_pkg::OP_MARK);
            end else begin
              cmd.res_status = ttba_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            cmd.res_status = ttba_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      ttba_pkg::S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.alloc      = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ttba_pkg::ST_SUCCESS;
          cmd.res_sel    = ttba_pkg::RES_FREE;
          state_nxt      = ttba_pkg::S_FINISH;
        end else if (stat.scan_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ttba_pkg::ST_NO_RESOURCE;
          state_nxt      = ttba_pkg::S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ttba_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ttba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ttba_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/ttba_datapath.sv */
// Datapath with descriptor table, block free map, first-fit scanner and result registers.
`timescale 1ns / 1ps
module ttba_datapath #(
  parameter int DESCRIPTORS = ttba_pkg::DESCRIPTORS_DEF,
  parameter int BLOCKS      = ttba_pkg::BLOCKS_DEF,
  parameter int BLOCK_BYTES = ttba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ttba_pkg::ttba_cmd_t             cmd,
  output ttba_pkg::ttba_stat_t            stat,
  input  logic [ttba_pkg::ADDR_W-1:0]     base_address,
  input  logic [1:0]                      in_op,
  input  logic [ttba_pkg::SRC_W-1:0]      in_source_id,
  input  logic [ttba_pkg::TID_W-1:0]      in_transfer_id,
  input  logic [ttba_pkg::SIZE_W-1:0]     in_xfer_size,
  output logic [ttba_pkg::STATUS_W-1:0]   out_status,
  output logic [ttba_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [ttba_pkg::ADDR_W-1:0]     out_block_address,
  output logic [ttba_pkg::COUNT_W-1:0]    out_block_count
);

  localparam int DW  = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
  localparam int IW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW  = $clog2(BLOCKS + 1);
  localparam int RBW = $clog2(BLOCKS * BLOCK_BYTES + 1);

  logic [1:0]                    op_r;
  logic [ttba_pkg::SRC_W-1:0]    src_r;
  logic [ttba_pkg::TID_W-1:0]    tid_r;
  logic [ttba_pkg::SIZE_W-1:0]   size_r;

  logic [DESCRIPTORS-1:0]        active_r, active_nxt;
  logic [DESCRIPTORS-1:0]        done_r, done_nxt;
  logic [ttba_pkg::SRC_W-1:0]    dsrc_r   [DESCRIPTORS];
  logic [ttba_pkg::TID_W-1:0]    dtid_r   [DESCRIPTORS];
  logic [IW-1:0]                 dfirst_r [DESCRIPTORS];
  logic [CW-1:0]                 dcnt_r   [DESCRIPTORS];

  logic [BLOCKS-1:0]             map_r, map_nxt;
  logic [IW-1:0]                 b_r;
  logic [CW-1:0]                 run_r;
  logic [RBW-1:0]                bytes_r;

  logic [ttba_pkg::STATUS_W-1:0] res_status_r;
  logic                          res_desc_r;
  logic [DW-1:0]                 res_slot_r;

  logic [ttba_pkg::STATUS_W-1:0] out_status_r;
  logic [ttba_pkg::SLOT_W-1:0]   out_slot_r;
  logic [ttba_pkg::ADDR_W-1:0]   out_addr_r;
  logic [ttba_pkg::COUNT_W-1:0]  out_count_r;

  logic                          hit, free_found;
  logic [DW-1:0]                 hit_idx, free_idx;
  logic [RBW-1:0]                bytes_inc;
  logic                          scan_hit;
  logic [IW-1:0]                 alloc_first;
  logic [IW:0]                   rel_end;
  logic [31:0]                   addr_calc;

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int d = 0; d < DESCRIPTORS; d++) begin
      if (!hit && active_r[d] && dsrc_r[d] == src_r && dtid_r[d] == tid_r) begin
        hit     = 1'b1;
        hit_idx = DW'(d);
      end
      if (!free_found && !active_r[d]) begin
        free_found = 1'b1;
        free_idx   = DW'(d);
      end
    end
  end

  assign bytes_inc   = bytes_r + RBW'(BLOCK_BYTES);
  assign scan_hit    = map_r[b_r] && (32'(bytes_inc) >= 32'(size_r));
  assign alloc_first = b_r - run_r[IW-1:0];
  assign rel_end     = (IW + 1)'(dfirst_r[hit_idx]) + (IW + 1)'(dcnt_r[hit_idx]);
  assign addr_calc   = 32'(base_address) + 32'(dfirst_r[res_slot_r]) * 32'(BLOCK_BYTES);

  always_comb begin
    stat.op         = op_r;
    stat.size_zero  = (size_r == '0);
    stat.hit        = hit;
    stat.hit_done   = done_r[hit_idx];
    stat.free_found = free_found;
    stat.scan_hit   = scan_hit;
    stat.scan_last  = (b_r == IW'(BLOCKS - 1));
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt   = done_r;
    map_nxt    = map_r;
    if (cmd.release_hit) begin
      active_nxt[hit_idx] = 1'b0;
      done_nxt[hit_idx]   = 1'b0;
      for (int j = 0; j < BLOCKS; j++) begin
        if ((IW + 1)'(j) >= (IW + 1)'(dfirst_r[hit_idx]) && (IW + 1)'(j) < rel_end) begin
          map_nxt[j] = 1'b1;
        end
      end
    end
    if (cmd.mark_hit) begin
      done_nxt[hit_idx] = 1'b1;
    end
    if (cmd.alloc) begin
      active_nxt[free_idx] = 1'b1;
      done_nxt[free_idx]   = 1'b0;
      for (int j = 0; j < BLOCKS; j++) begin
        if (IW'(j) >= alloc_first && IW'(j) <= b_r) begin
          map_nxt[j] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      done_r   <= '0;
      map_r    <= '1;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      map_r    <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      src_r  <= in_source_id;
      tid_r  <= in_transfer_id;
      size_r <= in_xfer_size;
    end
    if (cmd.scan_init) begin
      b_r     <= '0;
      run_r   <= '0;
      bytes_r <= '0;
    end else if (cmd.scan_step) begin
      b_r <= b_r + IW'(1);
      if (map_r[b_r]) begin
        run_r   <= run_r + CW'(1);
        bytes_r <= bytes_inc;
      end else begin
        run_r   <= '0;
        bytes_r <= '0;
      end
    end
    if (cmd.alloc) begin
      dsrc_r[free_idx]   <= src_r;
      dtid_r[free_idx]   <= tid_r;
      dfirst_r[free_idx] <= alloc_first;
      dcnt_r[free_idx]   <= run_r + CW'(1);
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_desc_r   <= (cmd.res_sel != ttba_pkg::RES_NONE);
      res_slot_r   <= (cmd.res_sel == ttba_pkg::RES_FREE) ? free_idx : hit_idx;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      if (res_desc_r) begin
        out_slot_r  <= ttba_pkg::SLOT_W'(res_slot_r);
        out_addr_r  <= addr_calc[ttba_pkg::ADDR_W-1:0];
        out_count_r <= ttba_pkg::COUNT_W'(dcnt_r[res_slot_r]);
      end else begin
        out_slot_r  <= '0;
        out_addr_r  <= '0;
        out_count_r <= '0;
      end
    end
  end

  assign out_status        = out_status_r;
  assign out_slot_index    = out_slot_r;
  assign out_block_address = out_addr_r;
  assign out_block_count   = out_count_r;

endmodule

/* rtl/core/transfer_table_block_allocator_top.sv */
// Top level of the transfer table block allocator with its configuration register.
//
//   Channel  Direction  Handshake         Payload
//   in       sink       in_valid/stall    op, source_id, transfer_id, xfer_size
//   out      source     out_valid/stall   status, slot_index, block_address, block_count
//   cfg      sink       APB psel/penable  base_address at byte address 0
//
// Release, mark-complete and opens settled at lookup go from S_DECIDE straight to S_FINISH.
// An open that scans the free map checks one block per cycle, from block 0 up to BLOCKS - 1.
// One request is in flight at a time; in_stall is high from accept until the result beat.
// A stalled result beat holds the finished request; the next one is taken meanwhile.
// Synchronous reset frees all descriptors and blocks; no clearing pass is needed.
`timescale 1ns / 1ps
module transfer_table_block_allocator_top #(
  parameter int DESCRIPTORS = ttba_pkg::DESCRIPTORS_DEF,
  parameter int BLOCKS      = ttba_pkg::BLOCKS_DEF,
  parameter int BLOCK_BYTES = ttba_pkg::BLOCK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [ttba_pkg::SRC_W-1:0]     in_source_id,
  input  logic [ttba_pkg::TID_W-1:0]     in_transfer_id,
  input  logic [ttba_pkg::SIZE_W-1:0]    in_xfer_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ttba_pkg::STATUS_W-1:0]  out_status,
  output logic [ttba_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [ttba_pkg::ADDR_W-1:0]    out_block_address,
  output logic [ttba_pkg::COUNT_W-1:0]   out_block_count,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttba_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  ttba_pkg::ttba_cmd_t            cmd;
  ttba_pkg::ttba_stat_t           stat;
  logic [ttba_pkg::ADDR_W-1:0]    base_r;
  logic                           reg_sel;

  assign reg_sel = (paddr[ttba_pkg::PADDR_W-1] == ttba_pkg::REG_BASE_ADDRESS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(base_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      base_r <= pwdata[ttba_pkg::ADDR_W-1:0];
    end
  end

  ttba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttba_datapath #(
    .DESCRIPTORS (DESCRIPTORS),
    .BLOCKS      (BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .base_address      (base_r),
    .in_op             (in_op),
    .in_source_id      (in_source_id),
    .in_transfer_id    (in_transfer_id),
    .in_xfer_size      (in_xfer_size),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_block_address (out_block_address),
    .out_block_count   (out_block_count)
  );

endmodule

/* rtl/core/ttba_checker.sv */
// Port-level checker for the transfer table block allocator and its bind.
`timescale 1ns / 1ps
`include "transfer_table_block_allocator_top_defines.svh"
module ttba_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ttba_pkg::STATUS_W-1:0]  out_status,
  input logic [ttba_pkg::SLOT_W-1:0]    out_slot_index,
  input logic [ttba_pkg::ADDR_W-1:0]    out_block_address,
  input logic [ttba_pkg::COUNT_W-1:0]   out_block_count
);

  `TTBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `TTBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second beat taken while busy")
  `TTBA_ASSERT_SAME(a_status_range, out_valid, out_status <= ttba_pkg::ST_BAD_SIZE, "status code out of range")
  `TTBA_ASSERT_SAME(a_no_desc_zero, out_valid && (out_status == ttba_pkg::ST_NO_RESOURCE || out_status == ttba_pkg::ST_NOT_FOUND || out_status == ttba_pkg::ST_BAD_SIZE), out_slot_index == '0 && out_block_address == '0 && out_block_count == '0, "fields not zero on failure")
  `TTBA_ASSERT_SAME(a_desc_count, out_valid && (out_status == ttba_pkg::ST_SUCCESS || out_status == ttba_pkg::ST_EXISTS || out_status == ttba_pkg::ST_COMPLETE), out_block_count != '0, "descriptor result with zero blocks")

endmodule

bind transfer_table_block_allocator_top ttba_checker u_ttba_checker (.*);
